@@ sv/hdtb_pkg.sv @@
// Package of the Huffman decode table builder: word types, action and
// status codes and fixed sizes. Depends on nothing.
`default_nettype none
package hdtb_pkg;

   // Action codes of an input word.
   localparam logic [2:0] ActLoadCount  = 3'd0;
   localparam logic [2:0] ActLoadSymbol = 3'd1;
   localparam logic [2:0] ActBuild      = 3'd2;
   localparam logic [2:0] ActReadLookup = 3'd3;
   localparam logic [2:0] ActReadTree   = 3'd4;
   localparam logic [2:0] ActReadLength = 3'd5;

   // Status codes of a result word.
   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StTooMany = 2'd1;
   localparam logic [1:0] StRange   = 2'd2;

   // Fixed sizes of the JPEG scheme.
   localparam int CodeLengths = 16;
   localparam int LookupBits  = 8;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] table_req;
      logic [8:0] address;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic signed [9:0] data;
      logic [1:0]        status;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/hdtb_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module hdtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ sv/huffman_decode_table_builder.sv @@
// Top level of the Huffman decode table builder: sequencer and five table RAMs.
// Depends on hdtb_pkg and hdtb_ram.
//
//   channel | direction | ports                          | word
//   request | in        | req_valid, req_stall, req_word | hdtb_pkg::req_type
//   result  | out       | rsp_valid, rsp_stall, rsp_word | hdtb_pkg::rsp_type
//
// Loads and flagged words are answered from the idle state; reads pass through a
// read state, set by the registered RAM read port. A build sums the sixteen counts,
// stops there if they exceed the symbol limit, else clears the table, then per
// symbol fills 2**(8-len) lookup entries for a short code or walks the tree bit by
// bit for a long one. After reset a clearing pass zeroes the count, lookup, tree
// and length RAMs before the first word is taken. The result register lets a
// new word in while the previous result is being taken; a stalled result holds the sequencer.
`default_nettype none
module huffman_decode_table_builder #(
   parameter int TABLE_COUNT = 4,
   parameter int MAX_SYMBOLS = 256,
   parameter int TREE_DEPTH  = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hdtb_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hdtb_pkg::rsp_type      rsp_word
);

   localparam int TW    = (TABLE_COUNT > 2) ? 2 : 1;
   localparam int SPW   = $clog2(MAX_SYMBOLS);
   localparam int TRW   = $clog2(TREE_DEPTH);
   localparam int LcAw  = TW + 4;
   localparam int SlAw  = TW + SPW;
   localparam int LuAw  = TW + hdtb_pkg::LookupBits;
   localparam int TrAw  = TW + TRW;
   localparam int InitW = TW + 9;
   localparam logic signed [10:0] NfLimit = 11'(1 - TREE_DEPTH);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_READ, S_SUM_RD, S_SUM_AC, S_CLEAR, S_SYM_NEXT,
      S_SYM_GOT, S_FILL, S_PL_LU, S_PL_BIT, S_PL_TR, S_RESP
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   hdtb_pkg::rsp_type rsp_ff;
   logic [InitW-1:0]  init_ff;
   logic [TW-1:0]     t_ff;
   logic [2:0]        rd_sel_ff;
   logic [1:0]        status_ff;
   logic [3:0]        i_ff;
   logic [11:0]       total_ff;
   logic [7:0]        counts_ff [hdtb_pkg::CodeLengths];
   logic [8:0]        j_ff;
   logic [4:0]        len_ff;
   logic [7:0]        k_ff;
   logic [SPW:0]      pos_ff;
   logic [15:0]       code_ff;
   logic [15:0]       c_ff;
   logic [7:0]        sym_ff;
   logic [7:0]        base_ff;
   logic [7:0]        fend_ff;
   logic [7:0]        top_ff;
   logic [3:0]        b_ff;
   logic signed [10:0] cur_ff;
   logic signed [10:0] nf_ff;
   logic [8:0]        idx_ff;

   // RAM ports.
   logic            lc_we, lc_re;
   logic [LcAw-1:0] lc_waddr, lc_raddr;
   logic [7:0]      lc_wdata, lc_rdata;
   logic            sl_we, sl_re;
   logic [SlAw-1:0] sl_waddr, sl_raddr;
   logic [7:0]      sl_wdata, sl_rdata;
   logic            lu_we, lu_re;
   logic [LuAw-1:0] lu_waddr, lu_raddr;
   logic [9:0]      lu_wdata, lu_rdata;
   logic            tr_we, tr_re;
   logic [TrAw-1:0] tr_waddr, tr_raddr;
   logic [9:0]      tr_wdata, tr_rdata;
   logic            cl_we, cl_re;
   logic [LuAw-1:0] cl_waddr, cl_raddr;
   logic [4:0]      cl_wdata, cl_rdata;

   // Decode of the offered word.
   logic          slot_free, acc, tbad, cnt_ok, sym_ok, lk_ok, tr_ok;
   logic [TW-1:0] tix;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);
   assign acc       = req_valid && !req_stall;
   assign tix       = req_word.table_req[TW-1:0];
   assign tbad      = (req_word.action <= hdtb_pkg::ActReadLength)
                      && (32'(req_word.table_req) >= TABLE_COUNT);
   assign cnt_ok    = (req_word.address >= 9'd1) && (req_word.address <= 9'd16);
   assign sym_ok    = {1'b0, req_word.address} < 10'(MAX_SYMBOLS);
   assign lk_ok     = !req_word.address[8];
   assign tr_ok     = {1'b0, req_word.address} < 10'(TREE_DEPTH);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Build-time helpers.
   logic [3:0]         cix;
   logic [11:0]        total_in;
   logic [7:0]         top;
   logic [3:0]         sh;
   logic signed [10:0] curn;
   logic [10:0]        idxw;
   logic               idx_ok, exhausted;
   logic [15:0]        cmask;

   assign cix       = 4'(len_ff - 5'd1);
   assign total_in  = total_ff + 12'(lc_rdata);
   assign top       = 8'(c_ff >> (len_ff - 5'd8));
   assign sh        = 4'(5'd8 - len_ff);
   assign curn      = c_ff[b_ff] ? cur_ff : cur_ff - 11'sd1;
   assign idxw      = ~curn;
   assign idx_ok    = !idxw[10] && (idxw < 11'(TREE_DEPTH));
   assign exhausted = nf_ff < NfLimit;
   assign cmask     = 16'((17'd1 << len_ff) - 17'd1);

   // RAM port steering by sequencer state.
   always_comb begin
      lc_we = 1'b0; lc_waddr = '0; lc_wdata = '0; lc_re = 1'b0; lc_raddr = '0;
      sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_re = 1'b0; sl_raddr = '0;
      lu_we = 1'b0; lu_waddr = '0; lu_wdata = '0; lu_re = 1'b0; lu_raddr = '0;
      tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_re = 1'b0; tr_raddr = '0;
      cl_we = 1'b0; cl_waddr = '0; cl_wdata = '0; cl_re = 1'b0; cl_raddr = '0;
      unique case (state_ff)
         S_INIT: begin
            lc_we = 1'b1; lc_waddr = init_ff[LcAw-1:0];
            lu_we = 1'b1; lu_waddr = init_ff[LuAw-1:0];
            tr_we = 1'b1; tr_waddr = init_ff[TrAw-1:0];
            cl_we = 1'b1; cl_waddr = init_ff[LuAw-1:0];
         end
         S_IDLE: begin
            if (acc && !tbad) begin
               lc_we    = (req_word.action == hdtb_pkg::ActLoadCount) && cnt_ok;
               lc_waddr = {tix, 4'(req_word.address - 9'd1)};
               lc_wdata = req_word.value;
               sl_we    = (req_word.action == hdtb_pkg::ActLoadSymbol) && sym_ok;
               sl_waddr = {tix, req_word.address[SPW-1:0]};
               sl_wdata = req_word.value;
               lu_re    = (req_word.action == hdtb_pkg::ActReadLookup) && lk_ok;
               lu_raddr = {tix, req_word.address[7:0]};
               tr_re    = (req_word.action == hdtb_pkg::ActReadTree) && tr_ok;
               tr_raddr = {tix, req_word.address[TRW-1:0]};
               cl_re    = (req_word.action == hdtb_pkg::ActReadLength) && lk_ok;
               cl_raddr = {tix, req_word.address[7:0]};
            end
         end
         S_SUM_RD: begin
            lc_re = 1'b1; lc_raddr = {t_ff, i_ff};
         end
         S_CLEAR: begin
            lu_we = !j_ff[8]; lu_waddr = {t_ff, j_ff[7:0]};
            cl_we = !j_ff[8]; cl_waddr = {t_ff, j_ff[7:0]};
            tr_we = {1'b0, j_ff} < 10'(TREE_DEPTH);
            tr_waddr = {t_ff, j_ff[TRW-1:0]};
         end
         S_SYM_NEXT: begin
            sl_re    = (len_ff <= 5'd16) && (k_ff != counts_ff[cix]);
            sl_raddr = {t_ff, pos_ff[SPW-1:0]};
         end
         S_SYM_GOT: begin
            cl_we    = 1'b1;
            cl_waddr = {t_ff, sl_rdata};
            cl_wdata = len_ff;
            lu_re    = len_ff > 5'd8;
            lu_raddr = {t_ff, top};
         end
         S_FILL: begin
            lu_we    = 1'b1;
            lu_waddr = {t_ff, 8'(base_ff + j_ff[7:0])};
            lu_wdata = {2'b00, sym_ff};
         end
         S_PL_LU: begin
            lu_we    = (lu_rdata == 10'd0) && !exhausted;
            lu_waddr = {t_ff, top_ff};
            lu_wdata = 10'(nf_ff);
         end
         S_PL_BIT: begin
            tr_we    = idx_ok && (b_ff == 4'd0);
            tr_waddr = {t_ff, idxw[TRW-1:0]};
            tr_wdata = {2'b00, sym_ff};
            tr_re    = idx_ok && (b_ff != 4'd0);
            tr_raddr = {t_ff, idxw[TRW-1:0]};
         end
         S_PL_TR: begin
            tr_we    = (tr_rdata == 10'd0) && !exhausted;
            tr_waddr = {t_ff, idx_ff[TRW-1:0]};
            tr_wdata = 10'(nf_ff);
         end
         default: begin
         end
      endcase
   end

   // A result word is loaded on an immediate answer, a finished read or a
   // finished build.
   logic rsp_load;

   assign rsp_load = ((state_ff == S_IDLE) && acc
                      && (tbad || ((req_word.action != hdtb_pkg::ActBuild)
                                   && !(lu_re || tr_re || cl_re))))
                     || (((state_ff == S_READ) || (state_ff == S_RESP)) && slot_free);

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         init_ff      <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (&init_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (acc) begin
                  t_ff      <= tix;
                  rd_sel_ff <= req_word.action;
                  if (tbad) begin
                     rsp_ff       <= '{data: '0, status: hdtb_pkg::StRange};
                  end else if (req_word.action == hdtb_pkg::ActBuild) begin
                     i_ff     <= '0;
                     total_ff <= '0;
                     state_ff <= S_SUM_RD;
                  end else if ((lu_re || tr_re || cl_re)) begin
                     state_ff <= S_READ;
                  end else begin
                     rsp_ff.data  <= '0;
                     if ((req_word.action == hdtb_pkg::ActLoadCount && !cnt_ok)
                         || (req_word.action == hdtb_pkg::ActLoadSymbol && !sym_ok)
                         || (req_word.action == hdtb_pkg::ActReadLookup)
                         || (req_word.action == hdtb_pkg::ActReadTree)
                         || (req_word.action == hdtb_pkg::ActReadLength)) begin
                        rsp_ff.status <= hdtb_pkg::StRange;
                     end else begin
                        rsp_ff.status <= hdtb_pkg::StOk;
                     end
                  end
               end
            end
            S_READ: begin
               if (slot_free) begin
                  rsp_ff.status <= hdtb_pkg::StOk;
                  priority if (rd_sel_ff == hdtb_pkg::ActReadLookup) begin
                     rsp_ff.data <= lu_rdata;
                  end else if (rd_sel_ff == hdtb_pkg::ActReadTree) begin
                     rsp_ff.data <= tr_rdata;
                  end else begin
                     rsp_ff.data <= {5'b00000, cl_rdata};
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_SUM_RD: begin
               state_ff <= S_SUM_AC;
            end
            S_SUM_AC: begin
               counts_ff[i_ff] <= lc_rdata;
               total_ff        <= total_in;
               i_ff            <= i_ff + 4'd1;
               if (i_ff == 4'd15) begin
                  if (total_in > 12'(MAX_SYMBOLS)) begin
                     status_ff <= hdtb_pkg::StTooMany;
                     state_ff  <= S_RESP;
                  end else begin
                     j_ff     <= '0;
                     state_ff <= S_CLEAR;
                  end
               end else begin
                  state_ff <= S_SUM_RD;
               end
            end
            S_CLEAR: begin
               j_ff <= j_ff + 9'd1;
               if (&j_ff) begin
                  len_ff   <= 5'd1;
                  k_ff     <= '0;
                  pos_ff   <= '0;
                  code_ff  <= '0;
                  nf_ff    <= -11'sd1;
                  state_ff <= S_SYM_NEXT;
               end
            end
            S_SYM_NEXT: begin
               if (len_ff > 5'd16) begin
                  status_ff <= hdtb_pkg::StOk;
                  state_ff  <= S_RESP;
               end else if (k_ff == counts_ff[cix]) begin
                  code_ff <= code_ff << 1;
                  len_ff  <= len_ff + 5'd1;
                  k_ff    <= '0;
               end else begin
                  c_ff     <= code_ff & cmask;
                  code_ff  <= code_ff + 16'd1;
                  pos_ff   <= pos_ff + 1'b1;
                  k_ff     <= k_ff + 8'd1;
                  state_ff <= S_SYM_GOT;
               end
            end
            S_SYM_GOT: begin
               sym_ff <= sl_rdata;
               if (len_ff <= 5'd8) begin
                  j_ff     <= '0;
                  base_ff  <= c_ff[7:0] << sh;
                  fend_ff  <= 8'((9'd1 << sh) - 9'd1);
                  state_ff <= S_FILL;
               end else begin
                  top_ff   <= top;
                  b_ff     <= 4'(len_ff - 5'd9);
                  state_ff <= S_PL_LU;
               end
            end
            S_FILL: begin
               j_ff <= j_ff + 9'd1;
               if (j_ff[7:0] == fend_ff) begin
                  state_ff <= S_SYM_NEXT;
               end
            end
            S_PL_LU: begin
               // An empty lookup entry gets a fresh tree node unless the tree is exhausted; a symbol there stops.
               if (lu_rdata == 10'd0) begin
                  if (exhausted) begin
                     state_ff <= S_SYM_NEXT;
                  end else begin
                     cur_ff   <= nf_ff;
                     nf_ff    <= nf_ff - 11'sd2;
                     state_ff <= S_PL_BIT;
                  end
               end else if (!lu_rdata[9]) begin
                  state_ff <= S_SYM_NEXT;
               end else begin
                  cur_ff   <= {lu_rdata[9], lu_rdata};
                  state_ff <= S_PL_BIT;
               end
            end
            S_PL_BIT: begin
               if (!idx_ok || (b_ff == 4'd0)) begin
                  state_ff <= S_SYM_NEXT;
               end else begin
                  idx_ff   <= idxw[8:0];
                  cur_ff   <= curn;
                  state_ff <= S_PL_TR;
               end
            end
            S_PL_TR: begin
               // Follow or allocate the node for this bit of the code.
               if (tr_rdata == 10'd0) begin
                  if (exhausted) begin
                     state_ff <= S_SYM_NEXT;
                  end else begin
                     cur_ff   <= nf_ff;
                     nf_ff    <= nf_ff - 11'sd2;
                     b_ff     <= b_ff - 4'd1;
                     state_ff <= S_PL_BIT;
                  end
               end else if (!tr_rdata[9]) begin
                  state_ff <= S_SYM_NEXT;
               end else begin
                  cur_ff   <= {tr_rdata[9], tr_rdata};
                  b_ff     <= b_ff - 4'd1;
                  state_ff <= S_PL_BIT;
               end
            end
            S_RESP: begin
               if (slot_free) begin
                  rsp_ff       <= '{data: '0, status: status_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   hdtb_ram #(.WIDTH(8), .DEPTH(2 ** LcAw)) u_counts (
      .clock(clock), .wr_en(lc_we), .wr_addr(lc_waddr), .wr_data(lc_wdata),
      .rd_en(lc_re), .rd_addr(lc_raddr), .rd_data(lc_rdata)
   );

   hdtb_ram #(.WIDTH(8), .DEPTH(2 ** SlAw)) u_symbols (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(sl_wdata),
      .rd_en(sl_re), .rd_addr(sl_raddr), .rd_data(sl_rdata)
   );

   hdtb_ram #(.WIDTH(10), .DEPTH(2 ** LuAw)) u_lookup (
      .clock(clock), .wr_en(lu_we), .wr_addr(lu_waddr), .wr_data(lu_wdata),
      .rd_en(lu_re), .rd_addr(lu_raddr), .rd_data(lu_rdata)
   );

   hdtb_ram #(.WIDTH(10), .DEPTH(2 ** TrAw)) u_tree (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_waddr), .wr_data(tr_wdata),
      .rd_en(tr_re), .rd_addr(tr_raddr), .rd_data(tr_rdata)
   );

   hdtb_ram #(.WIDTH(5), .DEPTH(2 ** LuAw)) u_lengths (
      .clock(clock), .wr_en(cl_we), .wr_addr(cl_waddr), .wr_data(cl_wdata),
      .rd_en(cl_re), .rd_addr(cl_raddr), .rd_data(cl_rdata)
   );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench of the Huffman decode table builder.
// Depends on hdtb_pkg and huffman_decode_table_builder; holds its own table predictor.
`default_nettype none
module tb_top;

   localparam int NumTables = 4;
   localparam int MaxSyms   = 256;
   localparam int TreeSize  = 512;
   localparam int CycleLimit = 3000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   hdtb_pkg::req_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   hdtb_pkg::rsp_type rsp_word;

   huffman_decode_table_builder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   // Predicted table state.
   logic [7:0]        cnt_mem   [NumTables][hdtb_pkg::CodeLengths];
   logic [7:0]        sym_mem   [NumTables][MaxSyms];
   logic signed [9:0] look_mem  [NumTables][256];
   logic signed [9:0] tree_mem  [NumTables][TreeSize];
   logic [4:0]        len_mem   [NumTables][256];
   bit                sym_known [NumTables][MaxSyms];

   hdtb_pkg::rsp_type expected_rsps[$];
   int  errors = 0;
   int  rsp_count = 0;
   int  builds_done = 0;
   int  words_sent = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_rsp = 1'b0;
   longint cycles = 0;

   // Walk one long code into the tree; mirrors the canonical placement rules.
   task automatic place_long_code(input int t, input int code, input int len,
                                  input int sym, inout int next_free);
      int top;
      int cur;
      int idx;
      top = (code >> (len - 8)) & 8'hFF;
      cur = look_mem[t][top];
      if (cur == 0) begin
         if (-next_free > TreeSize - 1) return;
         cur = next_free;
         look_mem[t][top] = 10'(cur);
         next_free -= 2;
      end else if (cur > 0) begin
         return;
      end
      for (int b = len - 9; b >= 0; b--) begin
         if (((code >> b) & 1) == 0) cur--;
         idx = -cur - 1;
         if (idx < 0 || idx >= TreeSize) return;
         if (b == 0) begin
            tree_mem[t][idx] = 10'(sym);
            return;
         end
         if (tree_mem[t][idx] == 0) begin
            if (-next_free > TreeSize - 1) return;
            tree_mem[t][idx] = 10'(next_free);
            cur = next_free;
            next_free -= 2;
         end else begin
            cur = tree_mem[t][idx];
            if (cur > 0) return;
         end
      end
   endtask

   task automatic build_tables(input int t, output logic [1:0] st);
      int total;
      int pos;
      int code;
      int next_free;
      int c;
      int sym;
      total = 0;
      pos = 0;
      code = 0;
      next_free = -1;
      for (int l = 0; l < hdtb_pkg::CodeLengths; l++) total += cnt_mem[t][l];
      if (total > MaxSyms) begin
         st = hdtb_pkg::StTooMany;
         return;
      end
      st = hdtb_pkg::StOk;
      for (int i = 0; i < 256; i++) begin
         look_mem[t][i] = '0;
         len_mem[t][i] = '0;
      end
      for (int i = 0; i < TreeSize; i++) tree_mem[t][i] = '0;
      for (int len = 1; len <= hdtb_pkg::CodeLengths; len++) begin
         for (int k = 0; k < cnt_mem[t][len-1]; k++) begin
            sym = sym_mem[t][pos];
            c = code & ((1 << len) - 1);
            pos++;
            code++;
            len_mem[t][sym] = 5'(len);
            if (len <= 8) begin
               for (int j = 0; j < (1 << (8 - len)); j++)
                  look_mem[t][((c << (8 - len)) + j) & 8'hFF] = 10'(sym);
            end else begin
               place_long_code(t, c, len, sym, next_free);
            end
         end
         code = code << 1;
      end
   endtask

   // Work out the result of one accepted word and update the predicted state.
   task automatic predict_word(input hdtb_pkg::req_type w);
      hdtb_pkg::rsp_type r;
      int t;
      int a;
      logic [1:0] st;
      r = '0;
      t = w.table_req;
      a = w.address;
      if (w.action <= hdtb_pkg::ActReadLength && t >= NumTables) begin
         r.status = hdtb_pkg::StRange;
      end else begin
         case (w.action)
            hdtb_pkg::ActLoadCount: begin
               if (a >= 1 && a <= hdtb_pkg::CodeLengths) cnt_mem[t][a-1] = w.value;
               else r.status = hdtb_pkg::StRange;
            end
            hdtb_pkg::ActLoadSymbol: begin
               if (a < MaxSyms) begin
                  sym_mem[t][a] = w.value;
                  sym_known[t][a] = 1'b1;
               end else r.status = hdtb_pkg::StRange;
            end
            hdtb_pkg::ActBuild: begin
               build_tables(t, st);
               r.status = st;
               builds_done++;
            end
            hdtb_pkg::ActReadLookup: begin
               if (a < 256) r.data = look_mem[t][a];
               else r.status = hdtb_pkg::StRange;
            end
            hdtb_pkg::ActReadTree: begin
               if (a < TreeSize) r.data = tree_mem[t][a];
               else r.status = hdtb_pkg::StRange;
            end
            hdtb_pkg::ActReadLength: begin
               if (a < 256) r.data = signed'(10'(len_mem[t][a]));
               else r.status = hdtb_pkg::StRange;
            end
            default: ;
         endcase
      end
      expected_rsps.push_back(r);
   endtask

   // Offer one word, with random idle cycles, and wait for it to be taken.
   task automatic send_word(input logic [2:0] act, input int t, input int a,
                            input int v);
      hdtb_pkg::req_type w;
      w.action = act;
      w.table_req = 2'(t);
      w.address = 9'(a);
      w.value = 8'(v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   // Before a build the symbol positions it will use must all have been loaded.
   function automatic bit build_is_safe(input int t);
      int total;
      total = 0;
      for (int l = 0; l < hdtb_pkg::CodeLengths; l++) total += cnt_mem[t][l];
      if (total > MaxSyms) return 1'b1;
      for (int i = 0; i < total; i++) if (!sym_known[t][i]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Load a table set with the given counts and random symbols.
   task automatic load_table(input int t, input int counts[hdtb_pkg::CodeLengths]);
      int total;
      total = 0;
      for (int l = 0; l < hdtb_pkg::CodeLengths; l++) begin
         send_word(hdtb_pkg::ActLoadCount, t, l + 1, counts[l]);
         total += counts[l];
      end
      for (int i = 0; i < total && i < MaxSyms; i++)
         send_word(hdtb_pkg::ActLoadSymbol, t, i, $urandom_range(255));
   endtask

   task automatic read_back(input int t, input int reads);
      for (int i = 0; i < reads; i++) begin
         case ($urandom_range(2))
            0: send_word(hdtb_pkg::ActReadLookup, t, $urandom_range(255),
                         $urandom_range(255));
            1: send_word(hdtb_pkg::ActReadTree, t, $urandom_range(TreeSize - 1),
                         $urandom_range(255));
            default: send_word(hdtb_pkg::ActReadLength, t, $urandom_range(255),
                               $urandom_range(255));
         endcase
      end
   endtask

   task automatic random_counts(output int counts[hdtb_pkg::CodeLengths]);
      int kind;
      kind = $urandom_range(3);
      for (int l = 0; l < hdtb_pkg::CodeLengths; l++) begin
         case (kind)
            0: counts[l] = (l < 8) ? $urandom_range(3) : $urandom_range(6);
            1: counts[l] = (l >= 8) ? $urandom_range(20) : 0;
            2: counts[l] = $urandom_range(2);
            default: counts[l] = (l == 1) ? 5 : (l >= 9 ? $urandom_range(12) : 1);
         endcase
      end
   endtask

   // Directed: extremes, every action, range errors, too many symbols.
   task automatic test_directed();
      int counts[hdtb_pkg::CodeLengths];
      counts = '{default: 0};
      send_word(hdtb_pkg::ActReadLookup, 0, 0, 0);
      send_word(hdtb_pkg::ActReadTree, 3, TreeSize - 1, 8'hFF);
      send_word(hdtb_pkg::ActReadLength, 1, 255, 0);
      send_word(hdtb_pkg::ActLoadCount, 0, 0, 8'hFF);
      send_word(hdtb_pkg::ActLoadCount, 0, 17, 8'hFF);
      send_word(hdtb_pkg::ActLoadSymbol, 2, 511, 8'hAA);
      send_word(hdtb_pkg::ActReadLookup, 0, 256, 0);
      send_word(hdtb_pkg::ActReadTree, 0, 511, 0);
      send_word(hdtb_pkg::ActReadLength, 0, 300, 0);
      send_word(3'd6, 0, 511, 8'hFF);
      send_word(3'd7, 3, 0, 0);
      // Counts summing above the symbol limit: status only, table unchanged.
      send_word(hdtb_pkg::ActLoadCount, 3, 16, 8'hFF);
      send_word(hdtb_pkg::ActLoadCount, 3, 1, 8'h80);
      send_word(hdtb_pkg::ActBuild, 3, 0, 0);
      send_word(hdtb_pkg::ActLoadCount, 3, 16, 0);
      send_word(hdtb_pkg::ActLoadCount, 3, 1, 0);
      send_word(hdtb_pkg::ActBuild, 3, 511, 8'hFF);
      // One symbol of each length, then 255 symbols of length 16 and one of length 15.
      for (int l = 0; l < hdtb_pkg::CodeLengths; l++) counts[l] = 1;
      load_table(0, counts);
      send_word(hdtb_pkg::ActBuild, 0, 0, 0);
      read_back(0, 8);
      counts = '{default: 0};
      counts[15] = 255;
      counts[14] = 1;
      load_table(1, counts);
      send_word(hdtb_pkg::ActBuild, 1, 0, 0);
      read_back(1, 10);
      // Oversubscribed short lengths wrap around.
      counts = '{default: 0};
      counts[0] = 3;
      counts[8] = 4;
      load_table(2, counts);
      send_word(hdtb_pkg::ActBuild, 2, 0, 0);
      read_back(2, 10);
      wait_drained();
   endtask

   // Random: mostly well-formed load-build-read sequences, some noise.
   task automatic test_random(input int words);
      int start;
      int t;
      int counts[hdtb_pkg::CodeLengths];
      logic [2:0] act;
      start = words_sent;
      while (words_sent - start < words) begin
         t = $urandom_range(NumTables - 1);
         if ($urandom_range(9) < 2) begin
            // Noise: random fields, builds only where every symbol is known.
            for (int i = 0; i < 10; i++) begin
               if ($urandom_range(1)) begin
                  act = 3'($urandom_range(7));
                  if (act == hdtb_pkg::ActBuild) act = hdtb_pkg::ActReadTree;
                  send_word(act, $urandom_range(3), $urandom_range(511),
                            $urandom_range(255));
               end else begin
                  send_word(hdtb_pkg::ActLoadCount, t, $urandom_range(17),
                            $urandom_range(255));
               end
            end
            if (build_is_safe(t)) send_word(hdtb_pkg::ActBuild, t, $urandom_range(511), 0);
         end else begin
            random_counts(counts);
            load_table(t, counts);
            send_word(hdtb_pkg::ActBuild, t, $urandom_range(511), $urandom_range(255));
            read_back(t, 20);
         end
      end
   endtask

   // Hold the result side off while words keep coming, to fill the block.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 40; i++)
            send_word(hdtb_pkg::ActReadLookup, $urandom_range(3), $urandom_range(255), 0);
      join
      wait_drained();
   endtask

   // Receiver stall.
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // Compare each taken result word with the oldest prediction.
   always @(posedge clock) begin
      hdtb_pkg::rsp_type exp_rsp;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result word data %0d status %0d", $time,
                     rsp_word.data, rsp_word.status);
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_word.data !== exp_rsp.data) begin
               $display("%0t: data mismatch, expected %0d, got %0d", $time,
                        exp_rsp.data, rsp_word.data);
               errors++;
            end
            if (rsp_word.status !== exp_rsp.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d", $time,
                        exp_rsp.status, rsp_word.status);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("huffman_decode_table_builder verification failed");
         $finish;
      end
   end

   initial begin
      for (int t = 0; t < NumTables; t++) begin
         for (int l = 0; l < hdtb_pkg::CodeLengths; l++) cnt_mem[t][l] = '0;
         for (int i = 0; i < 256; i++) begin
            look_mem[t][i] = '0;
            len_mem[t][i] = '0;
            sym_mem[t][i] = '0;
            sym_known[t][i] = 1'b0;
         end
         for (int i = 0; i < TreeSize; i++) tree_mem[t][i] = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 14;
      recv_idle_pct = 71;
      test_random(280);
      test_backpressure();
      send_idle_pct = 71;
      recv_idle_pct = 14;
      test_random(280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(280);
      wait_drained();
      repeat (20) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d expected result words never arrived", $time,
                  expected_rsps.size());
         errors++;
      end
      $display("Checked %0d result words over %0d table builds on all tables,", rsp_count,
               builds_done);
      $display("with range errors, oversized counts and long stretches of back-pressure.");
      if (errors == 0) begin
         $display("huffman_decode_table_builder verification clean");
      end else begin
         $display("huffman_decode_table_builder verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
